// ===== hdl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg: swept box collision package
// Number formats, register indexes, face codes and item types shared by the
// swept box collision pipeline.
// ----------------------------------------------------------------------------
package sac_pkg;

   // Q16.16 coordinates
   localparam int COORD_WIDTH     = 32;
   localparam int FRAC_BITS       = 16;
   localparam int MARGIN_WIDTH    = 21;
   localparam int NORMAL_WIDTH    = 3;
   localparam int AXES            = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = MARGIN_WIDTH;

   // derived widths
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;            // box differences
   localparam int QUO_WIDTH  = DIFF_WIDTH + FRAC_BITS;     // full quotient
   localparam int PROD_WIDTH = 2 * COORD_WIDTH;
   localparam int OFF_WIDTH  = PROD_WIDTH - FRAC_BITS;     // scaled offset
   localparam int ENT_WIDTH  =
      ((DIFF_WIDTH + 1 > MARGIN_WIDTH + 1) ? DIFF_WIDTH + 1 : MARGIN_WIDTH + 1) + 1;
   localparam int CMP_WIDTH  =
      ((OFF_WIDTH > ENT_WIDTH) ? OFF_WIDTH : ENT_WIDTH) + 2;
   localparam int RES_WIDTH  = COORD_WIDTH + 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MARGIN_X  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MARGIN_Y  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MARGIN_Z  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALLOWANCE = 2'd3;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // contact faces
   localparam logic [NORMAL_WIDTH-1:0] NORMAL_NONE  = 3'd0;
   localparam logic [NORMAL_WIDTH-1:0] NORMAL_NEG_X = 3'd1;
   localparam logic [NORMAL_WIDTH-1:0] NORMAL_POS_X = 3'd2;
   localparam logic [NORMAL_WIDTH-1:0] NORMAL_NEG_Y = 3'd3;
   localparam logic [NORMAL_WIDTH-1:0] NORMAL_POS_Y = 3'd4;
   localparam logic [NORMAL_WIDTH-1:0] NORMAL_NEG_Z = 3'd5;
   localparam logic [NORMAL_WIDTH-1:0] NORMAL_POS_Z = 3'd6;

   typedef struct packed {
      logic                          mode;
      logic signed [COORD_WIDTH-1:0] box_min_x;
      logic signed [COORD_WIDTH-1:0] box_min_y;
      logic signed [COORD_WIDTH-1:0] box_min_z;
      logic signed [COORD_WIDTH-1:0] box_max_x;
      logic signed [COORD_WIDTH-1:0] box_max_y;
      logic signed [COORD_WIDTH-1:0] box_max_z;
      logic signed [COORD_WIDTH-1:0] step_x;
      logic signed [COORD_WIDTH-1:0] step_y;
      logic signed [COORD_WIDTH-1:0] step_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] hit_fraction;
      logic [NORMAL_WIDTH-1:0]       normal_code;
   } rsp_type;

   // per-query geometry carried down the pipeline
   typedef struct packed {
      logic [AXES-1:0][DIFF_WIDTH-1:0]  rmin;
      logic [AXES-1:0][DIFF_WIDTH-1:0]  rmax;
      logic [AXES-1:0][DIFF_WIDTH-1:0]  size;
      logic [AXES-1:0][COORD_WIDTH-1:0] dv;
      logic [AXES-1:0]                  enter;
   } side_type;

   typedef struct packed {
      logic                            valid;
      side_type                        side;
      logic [AXES-1:0][DIFF_WIDTH-1:0] far;
   } entry_type;

   typedef struct packed {
      logic                             valid;
      side_type                         side;
      logic [AXES-1:0][DIFF_WIDTH-1:0]  nmag;
      logic [AXES-1:0][COORD_WIDTH-1:0] dmag;
      logic [AXES-1:0]                  neg;
      logic [AXES-1:0][COORD_WIDTH-1:0] rem;
      logic [AXES-1:0][QUO_WIDTH-1:0]   quo;
   } div_type;

   typedef struct packed {
      logic                             valid;
      side_type                         side;
      logic [AXES-1:0][COORD_WIDTH-1:0] sw;
   } time_type;

   typedef struct packed {
      logic                                  valid;
      side_type                              side;
      logic [AXES-1:0][COORD_WIDTH-1:0]      sw;
      logic [AXES-1:0][1:0][PROD_WIDTH-1:0] prod;
   } prod_type;

   typedef struct packed {
      logic                             valid;
      side_type                         side;
      logic [AXES-1:0][COORD_WIDTH-1:0] sw;
      logic [AXES-1:0]                  ok;
   } check_type;

endpackage

// ===== hdl/swept_aabb_collision.sv =====
// ----------------------------------------------------------------------------
// swept_aabb_collision: swept box collision pipeline
// Holds one moving box and its step; answers, for each static box queried,
// the fraction of the step until contact and the face that is hit.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            item
//   req_     in         req_valid/req_stall  load mover (mode 0) or query
//   rsp_     out        rsp_valid/rsp_stall  hit_fraction, normal_code
//   csr_     in         csr_write            margins, replacement allowance
//
// One item enters every cycle while req_stall is low. A query passes the
// entry stage, then the bit-per-stage divider, one quotient bit in each
// of 49 stages for all three axes in parallel, then the hit time, offset,
// overlap and result registers. A load gives no item and updates the mover
// at once for the next query. Reset clears valid bits, the mover and the
// registers. A stalled result freezes the whole pipeline, raising req_stall.
//
module swept_aabb_collision (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  sac_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output sac_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write,
   input  logic [sac_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sac_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int CW   = sac_pkg::COORD_WIDTH;
   localparam int FB   = sac_pkg::FRAC_BITS;
   localparam int NA   = sac_pkg::AXES;
   localparam int MW   = sac_pkg::MARGIN_WIDTH;
   localparam int DW   = sac_pkg::DIFF_WIDTH;
   localparam int QW   = sac_pkg::QUO_WIDTH;
   localparam int PW   = sac_pkg::PROD_WIDTH;
   localparam int OW   = sac_pkg::OFF_WIDTH;
   localparam int EW   = sac_pkg::ENT_WIDTH;
   localparam int KW   = sac_pkg::CMP_WIDTH;
   localparam int RW   = sac_pkg::RES_WIDTH;

   localparam logic [QW-1:0] QUO_LIM   = QW'(1) << (CW - 1);
   localparam logic [CW-1:0] MAG_LIM   = CW'(1) << (CW - 1);
   localparam logic [CW-1:0] POS_LIM   = MAG_LIM - CW'(1);
   localparam logic signed [RW-1:0] ONE_Q   = RW'(1) << FB;
   localparam logic signed [RW-1:0] SAT_POS = RW'(POS_LIM);
   localparam logic signed [RW-1:0] SAT_NEG = -(RW'(MAG_LIM));

   // ------------------------------------------------------------------
   // registers and stored mover
   // ------------------------------------------------------------------
   logic [NA-1:0][MW-1:0] margin_ff;
   logic                  allow_ff;
   logic [NA-1:0][CW-1:0] mover_min_ff, mover_max_ff, mover_step_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   sac_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic advance;
   logic take;

   // the whole pipeline moves unless a finished result is held back
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance || reset;
   assign take      = req_valid && !req_stall;

   logic [NA-1:0][CW-1:0] box_min_w, box_max_w, step_w;

   assign box_min_w = {req_data.box_min_z, req_data.box_min_y, req_data.box_min_x};
   assign box_max_w = {req_data.box_max_z, req_data.box_max_y, req_data.box_max_x};
   assign step_w    = {req_data.step_z, req_data.step_y, req_data.step_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff     <= '0;
         allow_ff      <= 1'b0;
         mover_min_ff  <= '0;
         mover_max_ff  <= '0;
         mover_step_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               sac_pkg::CSR_MARGIN_X:  margin_ff[0] <= csr_wdata[MW-1:0];
               sac_pkg::CSR_MARGIN_Y:  margin_ff[1] <= csr_wdata[MW-1:0];
               sac_pkg::CSR_MARGIN_Z:  margin_ff[2] <= csr_wdata[MW-1:0];
               sac_pkg::CSR_ALLOWANCE: allow_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
         // a load replaces the mover for every later query
         if (take && req_data.mode == sac_pkg::MODE_LOAD) begin
            mover_min_ff  <= box_min_w;
            mover_max_ff  <= box_max_w;
            mover_step_ff <= step_w;
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 1: box differences relative to the static minimum
   // ------------------------------------------------------------------
   sac_pkg::entry_type ent_ff, ent_in;

   always_comb begin
      ent_in            = '0;
      ent_in.valid      = take && req_data.mode == sac_pkg::MODE_QUERY;
      ent_in.side.dv    = mover_step_ff;
      ent_in.side.enter = '0;
      for (int a = 0; a < NA; a++) begin
         ent_in.side.rmin[a] = DW'($signed(mover_min_ff[a])) - DW'($signed(box_min_w[a]));
         ent_in.side.rmax[a] = DW'($signed(mover_max_ff[a])) - DW'($signed(box_min_w[a]));
         ent_in.side.size[a] = DW'($signed(box_max_w[a])) - DW'($signed(box_min_w[a]));
         // distance to the far face, same as size - rmin
         ent_in.far[a]       = DW'($signed(box_max_w[a])) - DW'($signed(mover_min_ff[a]));
      end
   end

   // ------------------------------------------------------------------
   // stage 2: entry test per axis, divider operands
   // ------------------------------------------------------------------
   sac_pkg::div_type div_ff [0:QW];
   sac_pkg::div_type div_in [0:QW];

   always_comb begin
      logic signed [EW-1:0] eps, allowv, lhs_pos, rhs_pos, lhs_neg;
      logic signed [DW-1:0] rmax_s, far_s;
      logic signed [CW-1:0] dv_s;
      logic                 moving, pos, test_pos, test_neg;

      div_in[0]       = '0;
      div_in[0].valid = ent_ff.valid;
      div_in[0].side  = ent_ff.side;
      for (int a = 0; a < NA; a++) begin
         dv_s     = $signed(ent_ff.side.dv[a]);
         rmax_s   = $signed(ent_ff.side.rmax[a]);
         far_s    = $signed(ent_ff.far[a]);
         moving   = dv_s != '0;
         pos      = moving && !dv_s[CW-1];
         eps      = EW'($signed({1'b0, margin_ff[a]}));
         allowv   = allow_ff ? EW'(dv_s) : '0;
         lhs_pos  = EW'($signed(ent_ff.side.rmin[a])) + allowv;
         rhs_pos  = EW'($signed(ent_ff.side.size[a])) - eps;
         lhs_neg  = EW'(rmax_s) + allowv;
         // strict on X and on the Y- face, non-strict elsewhere
         test_pos = (a == 2) ? (lhs_pos <= rhs_pos) : (lhs_pos < rhs_pos);
         test_neg = (a == 0) ? (lhs_neg > eps) : (lhs_neg >= eps);
         div_in[0].side.enter[a] = moving && (pos ? test_pos : test_neg);
         if (pos) begin
            div_in[0].nmag[a] = rmax_s[DW-1] ? DW'(-rmax_s) : DW'(rmax_s);
            div_in[0].neg[a]  = rmax_s > 0;
         end else begin
            div_in[0].nmag[a] = far_s[DW-1] ? DW'(-far_s) : DW'(far_s);
            div_in[0].neg[a]  = !far_s[DW-1];
         end
         div_in[0].dmag[a] = dv_s[CW-1] ? CW'(-dv_s) : CW'(dv_s);
      end
   end

   // ------------------------------------------------------------------
   // divider: one restoring step per stage, dividend is nmag << FRAC_BITS
   // ------------------------------------------------------------------
   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int POS = QW - 1 - j;
      logic [NA-1:0] bits;

      if (POS >= FB) begin : g_num
         for (genvar a = 0; a < NA; a++) begin : g_bit
            assign bits[a] = div_ff[j].nmag[a][POS-FB];
         end
      end else begin : g_zero
         assign bits = '0;
      end

      always_comb begin
         logic [CW:0] part, diff;
         logic        ge;
         div_in[j+1] = div_ff[j];
         for (int a = 0; a < NA; a++) begin
            part = {div_ff[j].rem[a], bits[a]};
            diff = part - {1'b0, div_ff[j].dmag[a]};
            ge   = part >= {1'b0, div_ff[j].dmag[a]};
            div_in[j+1].rem[a] = ge ? diff[CW-1:0] : part[CW-1:0];
            div_in[j+1].quo[a] = {div_ff[j].quo[a][QW-2:0], ge};
         end
      end
   end

   // ------------------------------------------------------------------
   // hit time: saturate, apply sign
   // ------------------------------------------------------------------
   sac_pkg::time_type tim_ff, tim_in;

   always_comb begin
      logic [CW-1:0] qs;
      tim_in.valid = div_ff[QW].valid;
      tim_in.side  = div_ff[QW].side;
      for (int a = 0; a < NA; a++) begin
         qs = (div_ff[QW].quo[a] > QUO_LIM) ? MAG_LIM : div_ff[QW].quo[a][CW-1:0];
         if (!div_ff[QW].neg[a] && qs > POS_LIM) begin
            qs = POS_LIM;
         end
         tim_in.sw[a] = div_ff[QW].neg[a] ? -qs : qs;
      end
   end

   // ------------------------------------------------------------------
   // offsets of the two other axes at the hit time
   // ------------------------------------------------------------------
   sac_pkg::prod_type prd_ff, prd_in;

   always_comb begin
      logic signed [PW-1:0] p0, p1;
      prd_in.valid = tim_ff.valid;
      prd_in.side  = tim_ff.side;
      prd_in.sw    = tim_ff.sw;
      for (int a = 0; a < NA; a++) begin
         p0 = $signed(tim_ff.side.dv[(a == 0) ? 1 : 0]) * $signed(tim_ff.sw[a]);
         p1 = $signed(tim_ff.side.dv[(a == 2) ? 1 : 2]) * $signed(tim_ff.sw[a]);
         prd_in.prod[a][0] = p0;
         prd_in.prod[a][1] = p1;
      end
   end

   // ------------------------------------------------------------------
   // overlap on the other two axes
   // ------------------------------------------------------------------
   sac_pkg::check_type chk_ff, chk_in;

   always_comb begin
      logic signed [OW-1:0] off;
      logic signed [KW-1:0] eps, lo_lhs, lo_rhs, hi_lhs;
      logic                 ok;
      int                   k;
      chk_in.valid = prd_ff.valid;
      chk_in.side  = prd_ff.side;
      chk_in.sw    = prd_ff.sw;
      for (int a = 0; a < NA; a++) begin
         ok = 1'b1;
         for (int n = 0; n < 2; n++) begin
            k = (n == 0) ? ((a == 0) ? 1 : 0) : ((a == 2) ? 1 : 2);
            // floor of the scaled product
            off    = $signed(prd_ff.prod[a][n][PW-1:FB]);
            eps    = KW'($signed({1'b0, margin_ff[k]}));
            lo_lhs = KW'($signed(prd_ff.side.rmin[k])) + KW'(off);
            lo_rhs = KW'($signed(prd_ff.side.size[k])) - eps;
            hi_lhs = KW'($signed(prd_ff.side.rmax[k])) + KW'(off);
            if (!(lo_lhs < lo_rhs) || !(hi_lhs > eps)) begin
               ok = 1'b0;
            end
         end
         chk_in.ok[a] = ok;
      end
   end

   // ------------------------------------------------------------------
   // axis order X, Y, Z: X wins outright, Y and Z only with a smaller
   // time, stop once the running time is below one
   // ------------------------------------------------------------------
   always_comb begin
      logic signed [RW-1:0]               res, swx;
      logic [sac_pkg::NORMAL_WIDTH-1:0]   code;
      logic                               done;
      res  = ONE_Q;
      code = sac_pkg::NORMAL_NONE;
      done = 1'b0;
      for (int a = 0; a < NA; a++) begin
         swx = RW'($signed(chk_ff.sw[a]));
         if (!done && chk_ff.side.enter[a] && chk_ff.ok[a] && (a == 0 || swx < res)) begin
            res = swx;
            case (a)
               0: code = chk_ff.side.dv[a][CW-1] ? sac_pkg::NORMAL_POS_X
                                                 : sac_pkg::NORMAL_NEG_X;
               1: code = chk_ff.side.dv[a][CW-1] ? sac_pkg::NORMAL_POS_Y
                                                 : sac_pkg::NORMAL_NEG_Y;
               default: code = chk_ff.side.dv[a][CW-1] ? sac_pkg::NORMAL_POS_Z
                                                       : sac_pkg::NORMAL_NEG_Z;
            endcase
         end
         if (res < ONE_Q) begin
            done = 1'b1;
         end
      end
      if (res > SAT_POS) begin
         res = SAT_POS;
      end else if (res < SAT_NEG) begin
         res = SAT_NEG;
      end
      rsp_valid_in             = chk_ff.valid;
      rsp_data_in.hit_fraction = res[CW-1:0];
      rsp_data_in.normal_code  = code;
   end

   // advance all stages together; clear only the valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
         for (int j = 0; j <= QW; j++) begin
            div_ff[j].valid <= 1'b0;
         end
         tim_ff.valid <= 1'b0;
         prd_ff.valid <= 1'b0;
         chk_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         ent_ff       <= ent_in;
         for (int j = 0; j <= QW; j++) begin
            div_ff[j] <= div_in[j];
         end
         tim_ff       <= tim_in;
         prd_ff       <= prd_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== dv/tb_swept_aabb_collision.sv =====
// ----------------------------------------------------------------------------
// tb_swept_aabb_collision: self-checking bench for the swept box collision
// Streams loads and queries through the valid/stall channels, predicts
// every contact fraction and face in the bench, and compares each result
// item in order. The margins and the allowance change between phases, and
// the idling pattern on both sides changes with them.
// ----------------------------------------------------------------------------
module tb_swept_aabb_collision;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  COORD_WIDTH     = sac_pkg::COORD_WIDTH;
   localparam int  FRAC_BITS       = sac_pkg::FRAC_BITS;
   localparam int  NORMAL_WIDTH    = sac_pkg::NORMAL_WIDTH;
   localparam int  CSR_INDEX_WIDTH = sac_pkg::CSR_INDEX_WIDTH;
   localparam int  CSR_DATA_WIDTH  = sac_pkg::CSR_DATA_WIDTH;

   localparam int  STALL_LIMIT = 20000;
   localparam int  DRAIN_WAIT  = 80;    // pipeline depth plus slack
   localparam int  ONE_Q       = 1 << FRAC_BITS;
   localparam int  PHASES      = 6;
   localparam int  PHASE_ITEMS = 222;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   sac_pkg::req_type           req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   sac_pkg::rsp_type           rsp_data;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   swept_aabb_collision dut (.*);

   always #5 clock = ~clock;

   // items waiting for the driver, and contacts waiting for the monitor
   sac_pkg::req_type items_to_send[$];
   sac_pkg::rsp_type contacts_due[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int unexpected     = 0;
   int loads_seen     = 0;
   int queries_seen   = 0;
   int faces_seen     = 0;
   int idle_cycles    = 0;

   // bench copy of the mover and registers
   longint mv_min[3], mv_max[3], mv_step[3];
   longint margin[3];
   bit     allowance;

   // signed fixed-point quotient: magnitude truncated, then saturated
   function automatic longint quotient_q(longint num, longint den);
      longint unsigned n, d, q, r, lim;
      bit neg, sat;
      n   = (num < 0) ? -num : num;
      d   = (den < 0) ? -den : den;
      neg = (num < 0) != (den < 0);
      lim = 64'd1 << (COORD_WIDTH - 1);
      q   = n / d;
      r   = n % d;
      sat = q > lim;
      for (int i = 0; i < FRAC_BITS && !sat; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q = q + 1;
         end
         if (q > lim) sat = 1'b1;
      end
      if (sat) q = lim;
      if (!neg && q > lim - 1) q = lim - 1;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // take one accepted item: store a mover, or work out the contact
   function automatic void sweep_predict(sac_pkg::req_type it);
      longint smin[3], smax[3], rmin[3], rmax[3], size[3], allow[3];
      longint best, sw, lhs, off;
      logic [NORMAL_WIDTH-1:0] face;
      bit enter, ok;
      sac_pkg::rsp_type res;
      smin = '{it.box_min_x, it.box_min_y, it.box_min_z};
      smax = '{it.box_max_x, it.box_max_y, it.box_max_z};
      if (it.mode == sac_pkg::MODE_LOAD) begin
         mv_min  = smin;
         mv_max  = smax;
         mv_step = '{it.step_x, it.step_y, it.step_z};
         loads_seen++;
         return;
      end
      queries_seen++;
      best = ONE_Q;
      face = sac_pkg::NORMAL_NONE;
      for (int a = 0; a < 3; a++) begin
         rmin[a]  = mv_min[a] - smin[a];
         rmax[a]  = mv_max[a] - smin[a];
         size[a]  = smax[a] - smin[a];
         allow[a] = allowance ? mv_step[a] : 0;
      end
      for (int a = 0; a < 3; a++) begin
         if (mv_step[a] != 0) begin
            ok = 1'b1;
            sw = 0;
            // strict entry on X and the lower Y face, non-strict elsewhere
            if (mv_step[a] > 0) begin
               lhs   = rmin[a] + allow[a];
               enter = (a == 2) ? (lhs <= size[a] - margin[a])
                                : (lhs <  size[a] - margin[a]);
               if (enter) sw = quotient_q(-rmax[a], mv_step[a]);
            end else begin
               lhs   = rmax[a] + allow[a];
               enter = (a == 0) ? (lhs > margin[a]) : (lhs >= margin[a]);
               if (enter) sw = quotient_q(size[a] - rmin[a], mv_step[a]);
            end
            if (enter) begin
               for (int k = 0; k < 3; k++) begin
                  if (k != a) begin
                     // product fits 63 bits; arithmetic shift floors
                     off = (mv_step[k] * sw) >>> FRAC_BITS;
                     if (!(rmin[k] + off < size[k] - margin[k]) ||
                         !(rmax[k] + off > margin[k]))
                        ok = 1'b0;
                  end
               end
               // X always wins; Y and Z only improve the running time
               if (ok && (a == 0 || sw < best)) begin
                  best = sw;
                  face = NORMAL_WIDTH'(2 * a + ((mv_step[a] > 0) ? 1 : 2));
               end
            end
         end
         if (a < 2 && best < ONE_Q) break;
      end
      if (face != sac_pkg::NORMAL_NONE) faces_seen++;
      res.hit_fraction = COORD_WIDTH'(best);
      res.normal_code  = face;
      contacts_due.push_back(res);
   endfunction

   // driver: advance to the next item once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= items_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // monitor: predict on acceptance, compare on delivery
   always @(posedge clock) begin
      sac_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) sweep_predict(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (contacts_due.size() == 0) begin
               unexpected++;
               if (mismatches + unexpected <= 10)
                  $display("%0t: result with nothing expected: frac %h face %0d",
                           $realtime, rsp_data.hit_fraction, rsp_data.normal_code);
            end else begin
               want = contacts_due.pop_front();
               if (rsp_data.hit_fraction !== want.hit_fraction ||
                   rsp_data.normal_code !== want.normal_code) begin
                  mismatches++;
                  if (mismatches + unexpected <= 10)
                     $display("%0t: mismatch: frac exp %h got %h, face exp %0d got %0d",
                              $realtime, want.hit_fraction, rsp_data.hit_fraction,
                              want.normal_code, rsp_data.normal_code);
               end
            end
         end
      end
   end

   // watchdog: stop if neither channel moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("swept_aabb_collision test failed");
            $finish;
         end
      end
   end

   function automatic int q_of(int n);
      return n * ONE_Q;
   endfunction

   function automatic int spread(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   task automatic push_item(logic m, int nx, int ny, int nz, int xx, int xy, int xz,
                            int sx, int sy, int sz);
      sac_pkg::req_type it;
      it.mode = m;
      it.box_min_x = nx; it.box_min_y = ny; it.box_min_z = nz;
      it.box_max_x = xx; it.box_max_y = xy; it.box_max_z = xz;
      it.step_x = sx; it.step_y = sy; it.step_z = sz;
      items_to_send.push_back(it);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, int val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_WIDTH'(val);
      case (idx)
         sac_pkg::CSR_MARGIN_X:  margin[0] = val & 32'h1F_FFFF;
         sac_pkg::CSR_MARGIN_Y:  margin[1] = val & 32'h1F_FFFF;
         sac_pkg::CSR_MARGIN_Z:  margin[2] = val & 32'h1F_FFFF;
         sac_pkg::CSR_ALLOWANCE: allowance = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // hold until the driver is empty and every contact is back, then let
   // any trailing loads clear the pipeline
   task automatic drain();
      while (items_to_send.size() != 0 || req_valid || contacts_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      int g_min[3], g_max[3], g_step[3], lo[3], hi[3], roll, fill;
      mv_min = '{0, 0, 0}; mv_max = '{0, 0, 0}; mv_step = '{0, 0, 0};
      margin = '{0, 0, 0};
      allowance = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: query against the cleared mover first
      push_item(sac_pkg::MODE_QUERY, 0, 0, 0, q_of(1), q_of(1), q_of(1), 0, 0, 0);
      // one load and one facing box per face direction
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), q_of(4), 0, 0);
      push_item(sac_pkg::MODE_QUERY, q_of(2), -q_of(1), -q_of(1), q_of(3), q_of(2), q_of(2),
                0, 0, 0);
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), -q_of(4), 0, 0);
      push_item(sac_pkg::MODE_QUERY, -q_of(3), -q_of(1), -q_of(1), -q_of(2), q_of(2),
                q_of(2), 0, 0, 0);
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), 0, q_of(4), 0);
      push_item(sac_pkg::MODE_QUERY, -q_of(1), q_of(2), -q_of(1), q_of(2), q_of(3), q_of(2),
                0, 0, 0);
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), 0, -q_of(4), 0);
      push_item(sac_pkg::MODE_QUERY, -q_of(1), -q_of(3), -q_of(1), q_of(2), -q_of(2),
                q_of(2), 0, 0, 0);
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), 0, 0, q_of(4));
      push_item(sac_pkg::MODE_QUERY, -q_of(1), -q_of(1), q_of(2), q_of(2), q_of(2), q_of(3),
                0, 0, 0);
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), 0, 0, -q_of(4));
      push_item(sac_pkg::MODE_QUERY, -q_of(1), -q_of(1), -q_of(3), q_of(2), q_of(2),
                -q_of(2), 0, 0, 0);
      // late hit on X: small step, far box
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), ONE_Q / 4,
                q_of(1) / 8, 0);
      push_item(sac_pkg::MODE_QUERY, q_of(5), -q_of(1), -q_of(1), q_of(6), q_of(2), q_of(2),
                0, 0, 0);
      // diagonal, so Y and Z compete after X misses
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), q_of(1), q_of(3),
                q_of(2));
      push_item(sac_pkg::MODE_QUERY, -q_of(4), q_of(2), q_of(2), q_of(4), q_of(6), q_of(6),
                0, 0, 0);
      // no displacement at all
      push_item(sac_pkg::MODE_LOAD, 0, 0, 0, q_of(1), q_of(1), q_of(1), 0, 0, 0);
      push_item(sac_pkg::MODE_QUERY, 0, 0, 0, q_of(1), q_of(1), q_of(1), 0, 0, 0);
      // field extremes and an inverted box
      push_item(sac_pkg::MODE_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000);
      push_item(sac_pkg::MODE_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 1);
      push_item(sac_pkg::MODE_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_item(sac_pkg::MODE_LOAD, q_of(3), 0, 0, q_of(1), q_of(1), q_of(1), 1, -1,
                32'h7FFF_FFFF);
      push_item(sac_pkg::MODE_QUERY, 32'h7FFF_FFFF, -q_of(1), 32'h8000_0000, 0, q_of(2), 0,
                0, 0, 0);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         // registers: cover zero, the top bit alone and the full 21 bits
         case (p)
            0: fill = 0;
            1: fill = 1 << 20;
            2: fill = (1 << 21) - 1;
            default: fill = -1;
         endcase
         write_reg(sac_pkg::CSR_MARGIN_X, (fill < 0) ? $urandom_range(1 << 18) : fill);
         write_reg(sac_pkg::CSR_MARGIN_Y, (fill < 0) ? $urandom_range(1 << 16) : fill);
         write_reg(sac_pkg::CSR_MARGIN_Z, (fill < 0) ? $urandom_range(1 << 20) : fill);
         write_reg(sac_pkg::CSR_ALLOWANCE, p % 2);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (n == 0 || roll < 10) begin
               // well-formed mover, occasionally still on some axes
               for (int a = 0; a < 3; a++) begin
                  g_min[a]  = spread(q_of(64));
                  g_max[a]  = g_min[a] + $urandom_range(q_of(4));
                  g_step[a] = ($urandom_range(3) == 0) ? 0 : spread(q_of(16));
               end
               push_item(sac_pkg::MODE_LOAD, g_min[0], g_min[1], g_min[2], g_max[0],
                         g_max[1], g_max[2], g_step[0], g_step[1], g_step[2]);
            end else if (roll < 15) begin
               // noise: every field random over its whole range
               push_item(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end else begin
               // static box placed around the mover's sweep
               for (int a = 0; a < 3; a++) begin
                  lo[a] = g_min[a] + spread(q_of(8) + (g_step[a] < 0 ? -g_step[a]
                                                                    : g_step[a]));
                  hi[a] = lo[a] + (($urandom_range(15) == 0) ? -$urandom_range(q_of(1))
                                                             : $urandom_range(q_of(6)));
               end
               push_item(sac_pkg::MODE_QUERY, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                         $urandom, $urandom, $urandom);
            end
         end
         drain();
      end

      $display("Covered %0d loads and %0d queries over %0d register settings;",
               loads_seen, queries_seen, PHASES + 1);
      $display("%0d queries reported a contact face, %0d mismatches, %0d unexpected.",
               faces_seen, mismatches, unexpected);
      if (mismatches == 0 && unexpected == 0 && contacts_due.size() == 0) begin
         $display("swept_aabb_collision test passed");
      end else begin
         $display("swept_aabb_collision test failed");
      end
      $finish;
   end

endmodule
